[sv/tts_pkg.sv]
package tts_pkg;

    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = 6;
    localparam int TASK_W = 8;
    localparam int TIME_W = 16;
    localparam int PEND_W = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD,
        KIND_DEL,
        KIND_TICK,
        KIND_DISP
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_RANGE
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_TICK,
        S_DISP,
        S_FLUSH
    } t_state;

    typedef enum logic {
        ALU_TICK,
        ALU_DISP
    } t_alu_op;

    typedef struct packed {
        logic [TASK_W-1:0] tid;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pend;
    } t_slot;

endpackage

[sv/tts_slot_alu.sv]
module tts_slot_alu import tts_pkg::*; (
    input  t_alu_op i_op,
    input  t_slot   i_slot,
    output t_slot   o_slot,
    output logic    o_hit
);

    logic occupied;

    assign occupied = (i_slot.tid != '0);

    always_comb begin
        o_slot = i_slot;
        o_hit  = 1'b0;
        case (i_op)
            ALU_TICK: begin
                if (occupied) begin
                    if (i_slot.delay == '0) begin
                        if (i_slot.pend != PEND_MAX) begin
                            o_slot.pend = PEND_W'(i_slot.pend + 1'b1);
                        end
                        if (i_slot.period != '0) begin
                            o_slot.delay = TIME_W'(i_slot.period - 1'b1);
                        end
                    end else begin
                        o_slot.delay = TIME_W'(i_slot.delay - 1'b1);
                    end
                end
            end
            ALU_DISP: begin
                if (occupied && (i_slot.pend != '0)) begin
                    o_hit       = 1'b1;
                    o_slot.pend = PEND_W'(i_slot.pend - 1'b1);
                    if (i_slot.period == '0) begin
                        o_slot = '0;
                    end
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

[sv/tick_task_scheduler_table.sv]
// Task slot table for a tick-driven cooperative scheduler. An item is taken when start is high
// and busy is low; its results come on the o_ ports for one cycle each, marked by o_strobe, and
// cannot be held off, so the receiver must take every strobed result. Add scans from slot 0 and
// finishes on the first free slot or, with none free, on the last slot. Tick and dispatch visit
// every slot in turn, one slot per cycle, through one slot update unit, and dispatch then passes
// through a flush state. Add and delete results appear in the cycle after the deciding slot is
// visited. A dispatch hit is held back until the next hit is found, and then appears in the
// cycle after that, or until the scan ends, and then passes through the flush state first; the
// last result of an item (o_last high) appears in the first cycle that busy is low again. Tick
// gives no result, nor does a dispatch with nothing due.
module tick_task_scheduler_table import tts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [TASK_W-1:0] i_task_id,
    input  logic [TIME_W-1:0] i_start_delay,
    input  logic [TIME_W-1:0] i_repeat_period,
    input  logic [SLOT_W-1:0] i_slot_index,
    output logic              o_strobe,
    output logic [SLOT_W-1:0] o_slot,
    output logic [TASK_W-1:0] o_run_task,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    t_slot             r_slots [SLOTS];

    logic [TASK_W-1:0] r_tid;
    logic [TIME_W-1:0] r_dly;
    logic [TIME_W-1:0] r_per;
    logic [SLOT_W-1:0] r_sidx;

    logic              r_held_valid, n_held_valid;
    logic [SLOT_W-1:0] r_held_slot, n_held_slot;
    logic [TASK_W-1:0] r_held_task, n_held_task;

    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [TASK_W-1:0] r_out_task, n_out_task;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    logic              w_en;
    logic [IDX_W-1:0]  w_addr;
    t_slot             w_data;

    t_slot             rd_slot;
    t_slot             alu_slot;
    logic              alu_hit;
    t_alu_op           alu_op;
    logic              accept;
    logic              scan_end;
    logic              rd_free;
    logic              del_ok;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign rd_slot  = r_slots[r_cnt];
    assign rd_free  = (rd_slot.tid == '0);
    assign scan_end = (r_cnt == IDX_W'(SLOTS - 1));
    assign del_ok   = ({1'b0, r_sidx} < (SLOT_W + 1)'(SLOTS));
    assign alu_op   = (r_state == S_DISP) ? ALU_DISP : ALU_TICK;

    tts_slot_alu u_alu (
        .i_op   (alu_op),
        .i_slot (rd_slot),
        .o_slot (alu_slot),
        .o_hit  (alu_hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_kind'(i_kind))
                        KIND_ADD:  n_state = S_ADD;
                        KIND_DEL:  n_state = S_DEL;
                        KIND_TICK: n_state = S_TICK;
                        KIND_DISP: n_state = S_DISP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (rd_free || scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                n_state = S_IDLE;
            end
            S_TICK: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                if (scan_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb begin
        n_cnt        = IDX_W'(r_cnt + 1'b1);
        n_held_valid = r_held_valid;
        n_held_slot  = r_held_slot;
        n_held_task  = r_held_task;
        n_out_valid  = 1'b0;
        n_out_slot   = '0;
        n_out_task   = '0;
        n_out_status = ST_OK;
        n_out_last   = 1'b0;
        w_en         = 1'b0;
        w_addr       = r_cnt;
        w_data       = alu_slot;
        case (r_state)
            S_IDLE: begin
                n_cnt        = '0;
                n_held_valid = 1'b0;
            end
            S_ADD: begin
                if (rd_free) begin
                    w_en        = 1'b1;
                    w_data      = '{tid: r_tid, delay: r_dly, period: r_per, pend: '0};
                    n_out_valid = 1'b1;
                    n_out_slot  = SLOT_W'(r_cnt);
                    n_out_last  = 1'b1;
                end else if (scan_end) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_FULL;
                    n_out_last   = 1'b1;
                end
            end
            S_DEL: begin
                n_out_valid = 1'b1;
                n_out_slot  = r_sidx;
                n_out_last  = 1'b1;
                if (del_ok) begin
                    w_en   = 1'b1;
                    w_addr = r_sidx[IDX_W-1:0];
                    w_data = '0;
                end else begin
                    n_out_status = ST_RANGE;
                end
            end
            S_TICK: begin
                w_en = 1'b1;
            end
            S_DISP: begin
                w_en = 1'b1;
                if (alu_hit) begin
                    // hold each hit back until the next one so the final one can carry last
                    n_out_valid  = r_held_valid;
                    n_out_slot   = r_held_slot;
                    n_out_task   = r_held_task;
                    n_held_valid = 1'b1;
                    n_held_slot  = SLOT_W'(r_cnt);
                    n_held_task  = rd_slot.tid;
                end
            end
            S_FLUSH: begin
                n_out_valid  = r_held_valid;
                n_out_slot   = r_held_slot;
                n_out_task   = r_held_task;
                n_out_last   = 1'b1;
                n_held_valid = 1'b0;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else if (w_en) begin
            r_slots[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tid  <= i_task_id;
            r_dly  <= i_start_delay;
            r_per  <= i_repeat_period;
            r_sidx <= i_slot_index;
        end
        r_held_slot  <= n_held_slot;
        r_held_task  <= n_held_task;
        r_out_slot   <= n_out_slot;
        r_out_task   <= n_out_task;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_strobe   = r_out_valid;
    assign o_slot     = r_out_slot;
    assign o_run_task = r_out_task;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

`ifndef SYNTHESIS
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state != S_IDLE))
        else $error("result without work in progress");

    a_full_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL)) |-> (r_out_slot == '0))
        else $error("table full result with nonzero slot");

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_task != '0)) |-> (r_out_status == ST_OK))
        else $error("dispatch result with error status");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("transfer taken but block not busy");
`endif

endmodule

[sim/tb_tick_task_scheduler_table.sv]
module tb_tick_task_scheduler_table import tts_pkg::*; ();

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 256;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TASK_W-1:0] run_task;
        t_status           status;
        logic              is_last;
    } t_sched_result;

    class t_slot_table_checker;
        logic [TASK_W-1:0] tid_of   [SLOTS];
        logic [TIME_W-1:0] delay_of [SLOTS];
        logic [TIME_W-1:0] period_of[SLOTS];
        logic [PEND_W-1:0] runs_of  [SLOTS];
        t_sched_result     awaited[$];
        int                errors;

        function new();
            errors = 0;
            for (int i = 0; i < SLOTS; i++) clear_slot(i);
        endfunction

        function void clear_slot(int i);
            tid_of[i]    = '0;
            delay_of[i]  = '0;
            period_of[i] = '0;
            runs_of[i]   = '0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        task automatic report(string what, int got, int want);
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // advance the slot table by one accepted transfer and queue its results
        task automatic note_command(t_kind kind, logic [TASK_W-1:0] tid,
                                    logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per,
                                    logic [SLOT_W-1:0] idx);
            t_sched_result r;
            t_sched_result batch[$];
            int free_slot;
            free_slot = -1;
            case (kind)
                KIND_ADD: begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (tid_of[i] == '0) free_slot = i;
                    if (free_slot < 0) begin
                        r = '{slot: '0, run_task: '0, status: ST_FULL, is_last: 1'b1};
                    end else begin
                        tid_of[free_slot]    = tid;
                        delay_of[free_slot]  = dly;
                        period_of[free_slot] = per;
                        runs_of[free_slot]   = '0;
                        r = '{slot: SLOT_W'(free_slot), run_task: '0, status: ST_OK,
                              is_last: 1'b1};
                    end
                    batch.push_back(r);
                end
                KIND_DEL: begin
                    if (idx >= SLOTS) begin
                        r = '{slot: idx, run_task: '0, status: ST_RANGE, is_last: 1'b1};
                    end else begin
                        clear_slot(int'(idx));
                        r = '{slot: idx, run_task: '0, status: ST_OK, is_last: 1'b1};
                    end
                    batch.push_back(r);
                end
                KIND_TICK: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tid_of[i] != '0) begin
                            if (delay_of[i] == '0) begin
                                if (runs_of[i] != PEND_MAX) runs_of[i] = runs_of[i] + 1'b1;
                                if (period_of[i] != '0) delay_of[i] = period_of[i] - 1'b1;
                            end else begin
                                delay_of[i] = delay_of[i] - 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tid_of[i] != '0 && runs_of[i] != '0) begin
                            r = '{slot: SLOT_W'(i), run_task: tid_of[i], status: ST_OK,
                                  is_last: 1'b0};
                            batch.push_back(r);
                            runs_of[i] = runs_of[i] - 1'b1;
                            if (period_of[i] == '0) clear_slot(i);
                        end
                    end
                    if (batch.size() > 0) begin
                        r = batch.pop_back();
                        r.is_last = 1'b1;
                        batch.push_back(r);
                    end
                end
            endcase
            foreach (batch[k]) awaited.push_back(batch[k]);
        endtask

        task automatic check_result(logic [SLOT_W-1:0] slot, logic [TASK_W-1:0] run_task,
                                    logic [STAT_W-1:0] status, logic is_last);
            t_sched_result want;
            if (awaited.size() == 0) begin
                report("unexpected result, slot", slot, -1);
            end else begin
                want = awaited.pop_front();
                if (slot !== want.slot) report("slot", slot, want.slot);
                if (run_task !== want.run_task) report("run_task", run_task, want.run_task);
                if (status !== want.status) report("status", status, want.status);
                if (is_last !== want.is_last) report("last", is_last, want.is_last);
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] i_kind = '0;
    logic [TASK_W-1:0] i_task_id = '0;
    logic [TIME_W-1:0] i_start_delay = '0;
    logic [TIME_W-1:0] i_repeat_period = '0;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic              o_strobe;
    logic [SLOT_W-1:0] o_slot;
    logic [TASK_W-1:0] o_run_task;
    logic [STAT_W-1:0] o_status;
    logic              o_last;

    t_slot_table_checker sb;
    int                  stall_cycles = 0;
    bit                  gaps_on = 1'b1;

    tick_task_scheduler_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_task_id       (i_task_id),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_index    (i_slot_index),
        .o_strobe        (o_strobe),
        .o_slot          (o_slot),
        .o_run_task      (o_run_task),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // transfers and results are both sampled here, in one process
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_command(t_kind'(i_kind), i_task_id, i_start_delay, i_repeat_period,
                                i_slot_index);
            if (o_strobe)
                sb.check_result(o_slot, o_run_task, o_status, o_last);
            if ((start && !busy) || o_strobe) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic issue(t_kind kind, logic [TASK_W-1:0] tid, logic [TIME_W-1:0] dly,
                         logic [TIME_W-1:0] per, logic [SLOT_W-1:0] idx);
        sender_gap();
        start           <= 1'b1;
        i_kind          <= kind;
        i_task_id       <= tid;
        i_start_delay   <= dly;
        i_repeat_period <= per;
        i_slot_index    <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (2 * SLOTS + 4) @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        logic [TASK_W-1:0] tid;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] per;
        logic [SLOT_W-1:0] idx;
        pick = $urandom_range(0, 99);
        tid  = TASK_W'($urandom);
        dly  = TIME_W'($urandom);
        per  = TIME_W'($urandom);
        idx  = SLOT_W'($urandom);
        if (pick < 25) begin
            if ($urandom_range(0, 31) == 0) tid = '0;
            else tid = TASK_W'($urandom_range(1, 255));
            if ($urandom_range(0, 7) != 0) dly = TIME_W'($urandom_range(0, 3));
            if ($urandom_range(0, 7) != 0) per = TIME_W'($urandom_range(0, 4));
            issue(KIND_ADD, tid, dly, per, idx);
        end else if (pick < 40) begin
            if ($urandom_range(0, 5) != 0) idx = SLOT_W'($urandom_range(0, SLOTS - 1));
            else idx = SLOT_W'($urandom_range(SLOTS, 63));
            issue(KIND_DEL, tid, dly, per, idx);
        end else if (pick < 72) begin
            issue(KIND_TICK, tid, dly, per, idx);
        end else begin
            issue(KIND_DISP, tid, dly, per, idx);
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, id zero, full table, range errors, extremes
        issue(KIND_DISP, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
        issue(KIND_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
        issue(KIND_ADD, 8'hFF, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_ADD, 8'h01, 16'hFFFF, 16'hFFFF, 6'h00);
        issue(KIND_ADD, 8'h00, 16'h0000, 16'h0001, 6'h00);
        issue(KIND_ADD, 8'h80, 16'h0001, 16'h0002, 6'h00);
        issue(KIND_ADD, 8'h55, 16'h0000, 16'h0001, 6'h00);
        issue(KIND_ADD, 8'hAA, 16'h0002, 16'h0000, 6'h00);
        issue(KIND_ADD, 8'h0F, 16'h0000, 16'h0003, 6'h00);
        issue(KIND_ADD, 8'hF0, 16'h0001, 16'h0000, 6'h00);
        issue(KIND_ADD, 8'h3C, 16'h8000, 16'h7FFF, 6'h00);
        issue(KIND_ADD, 8'hC3, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_DEL, 8'h00, 16'h0000, 16'h0000, 6'h3F);
        issue(KIND_DEL, 8'h00, 16'h0000, 16'h0000, 6'(SLOTS));
        issue(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_DISP, 8'h00, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_DEL, 8'h00, 16'h0000, 16'h0000, 6'(SLOTS - 1));
        issue(KIND_DEL, 8'h00, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_ADD, 8'h7F, 16'h0000, 16'hFFFF, 6'h00);
        issue(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 6'h00);
        issue(KIND_DISP, 8'h00, 16'h0000, 16'h0000, 6'h00);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 25 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (n >= RANDOM_ITEMS - 40) gaps_on = 1'b0;
            if (n == RANDOM_ITEMS / 2) drain();
            random_item();
        end
        drain();

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
